FILE: hdl/nvc_pkg.sv
// Shared types, character constants and the sequencer program for the
// natural version compare block. No dependencies.
`default_nettype none

package nvc_pkg;

	// Default string capacity
	localparam int MAX_LEN_DEF = 64;

	// Command opcodes
	localparam logic [1:0] OP_APPEND_FIRST  = 2'd0;
	localparam logic [1:0] OP_APPEND_SECOND = 2'd1;
	localparam logic [1:0] OP_COMPARE       = 2'd2;

	// Characters the compare looks at
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_A    = 8'h61;
	localparam logic [7:0] CH_N    = 8'h6e;
	localparam logic [7:0] CH_Y    = 8'h79;

	// Program counter
	localparam int PC_W = 5;
	typedef logic [PC_W-1:0] pc_t;

	// Program steps
	localparam pc_t PC_CHK_ANY    = 5'd0;
	localparam pc_t PC_FETCH_AB   = 5'd1;
	localparam pc_t PC_LATCH_AB   = 5'd2;
	localparam pc_t PC_TEST_DIG   = 5'd3;
	localparam pc_t PC_ZERO_A     = 5'd4;
	localparam pc_t PC_FETCH_A    = 5'd5;
	localparam pc_t PC_LATCH_A    = 5'd6;
	localparam pc_t PC_ZERO_B     = 5'd7;
	localparam pc_t PC_FETCH_B    = 5'd8;
	localparam pc_t PC_LATCH_B    = 5'd9;
	localparam pc_t PC_RUN_TEST   = 5'd10;
	localparam pc_t PC_RUN_FETCH  = 5'd11;
	localparam pc_t PC_RUN_LATCH  = 5'd12;
	localparam pc_t PC_RUN_LEN    = 5'd13;
	localparam pc_t PC_RUN_DIFF   = 5'd14;
	localparam pc_t PC_LOOP_TEST  = 5'd15;
	localparam pc_t PC_RES_SUB    = 5'd16;
	localparam pc_t PC_RES_SIGN   = 5'd17;
	localparam pc_t PC_RES_DIFF   = 5'd18;
	localparam pc_t PC_RES_ZERO   = 5'd19;
	localparam pc_t PC_LAST       = PC_RES_ZERO;

	// Jump conditions
	typedef logic [3:0] cond_t;
	localparam cond_t C_NONE        = 4'd0;
	localparam cond_t C_ALWAYS      = 4'd1;
	localparam cond_t C_ANY         = 4'd2;
	localparam cond_t C_NOT_BOTH    = 4'd3;
	localparam cond_t C_A_NOT_ZERO  = 4'd4;
	localparam cond_t C_B_NOT_ZERO  = 4'd5;
	localparam cond_t C_DIG_DIFFER  = 4'd6;
	localparam cond_t C_DIFF_NZ     = 4'd7;
	localparam cond_t C_CONTINUE    = 4'd8;

	// Result selection
	typedef logic [2:0] res_t;
	localparam res_t RES_NONE = 3'd0;
	localparam res_t RES_SUB  = 3'd1;
	localparam res_t RES_SIGN = 3'd2;
	localparam res_t RES_DIFF = 3'd3;
	localparam res_t RES_ZERO = 3'd4;

	// One control word
	typedef struct packed {
		cond_t cond;
		pc_t   target;
		logic  inc_i;
		logic  inc_j;
		logic  lat_a;
		logic  lat_b;
		logic  diff_upd;
		res_t  res_sel;
	} ctrl_word_t;

	// Status of one string store toward the sequencer
	typedef struct packed {
		logic [7:0] ch;
		logic       is_any;
		logic       full;
	} store_stat_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	// Program ROM
	function automatic ctrl_word_t rom_word(input pc_t pc);
		ctrl_word_t w;
		w = '0;
		case (pc)
			PC_CHK_ANY: begin
				w.cond = C_ANY;
				w.target = PC_RES_ZERO;
			end
			PC_FETCH_AB: begin
				w.inc_i = 1'b1;
				w.inc_j = 1'b1;
			end
			PC_LATCH_AB: begin
				w.lat_a = 1'b1;
				w.lat_b = 1'b1;
			end
			PC_TEST_DIG: begin
				w.cond = C_NOT_BOTH;
				w.target = PC_LOOP_TEST;
			end
			PC_ZERO_A: begin
				w.cond = C_A_NOT_ZERO;
				w.target = PC_ZERO_B;
			end
			PC_FETCH_A: begin
				w.inc_i = 1'b1;
			end
			PC_LATCH_A: begin
				w.lat_a = 1'b1;
				w.cond = C_ALWAYS;
				w.target = PC_ZERO_A;
			end
			PC_ZERO_B: begin
				w.cond = C_B_NOT_ZERO;
				w.target = PC_RUN_TEST;
			end
			PC_FETCH_B: begin
				w.inc_j = 1'b1;
			end
			PC_LATCH_B: begin
				w.lat_b = 1'b1;
				w.cond = C_ALWAYS;
				w.target = PC_ZERO_B;
			end
			PC_RUN_TEST: begin
				w.cond = C_NOT_BOTH;
				w.target = PC_RUN_LEN;
			end
			PC_RUN_FETCH: begin
				w.diff_upd = 1'b1;
				w.inc_i = 1'b1;
				w.inc_j = 1'b1;
			end
			PC_RUN_LATCH: begin
				w.lat_a = 1'b1;
				w.lat_b = 1'b1;
				w.cond = C_ALWAYS;
				w.target = PC_RUN_TEST;
			end
			PC_RUN_LEN: begin
				w.cond = C_DIG_DIFFER;
				w.target = PC_RES_SIGN;
			end
			PC_RUN_DIFF: begin
				w.cond = C_DIFF_NZ;
				w.target = PC_RES_DIFF;
			end
			PC_LOOP_TEST: begin
				w.cond = C_CONTINUE;
				w.target = PC_FETCH_AB;
			end
			PC_RES_SUB:  w.res_sel = RES_SUB;
			PC_RES_SIGN: w.res_sel = RES_SIGN;
			PC_RES_DIFF: w.res_sel = RES_DIFF;
			PC_RES_ZERO: w.res_sel = RES_ZERO;
			default:     w.res_sel = RES_ZERO;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/nvc_store.sv
// One string store: character memory, fill length, "any" tracker and a
// registered read port. Depends on nvc_pkg.
`default_nettype none

module nvc_store #(
	parameter int MAX_LEN = nvc_pkg::MAX_LEN_DEF,
	localparam int IW = $clog2(MAX_LEN + 2),
	localparam int LW = $clog2(MAX_LEN + 1),
	localparam int AW = $clog2(MAX_LEN)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [7:0]        push_char,
	input  wire logic              clear,
	input  wire logic [IW-1:0]     rd_idx,
	output nvc_pkg::store_stat_t   stat
);

	logic [7:0]    mem [MAX_LEN];
	logic [LW-1:0] len_q;
	logic          any_q;
	logic [7:0]    rd_q;
	logic          hit_q;
	logic          full;
	logic          wr;

	assign full = (len_q == LW'(MAX_LEN));
	assign wr   = push && !full;

	// Write at the fill point, read at the walk index
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[len_q[AW-1:0]] <= push_char;
		end
		rd_q <= mem[rd_idx[AW-1:0]];
	end

	// Track length, whether the read hit a held character, and "any"
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			any_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			hit_q <= (rd_idx < IW'(len_q));
			if (clear) begin
				len_q <= '0;
			end else if (wr) begin
				len_q <= len_q + LW'(1);
				if (len_q == LW'(0)) begin
					any_q <= (push_char == nvc_pkg::CH_A);
				end else if (len_q == LW'(1)) begin
					any_q <= any_q && (push_char == nvc_pkg::CH_N);
				end else if (len_q == LW'(2)) begin
					any_q <= any_q && (push_char == nvc_pkg::CH_Y);
				end
			end
		end
	end

	// Past the end reads as the terminator
	assign stat.ch     = hit_q ? rd_q : nvc_pkg::CH_NUL;
	assign stat.is_any = (len_q == LW'(3)) && any_q;
	assign stat.full   = full;

endmodule

`default_nettype wire

FILE: hdl/natural_version_compare.sv
// Top level of the natural version compare block: command channel, microcoded
// sequencer and result register. Depends on nvc_pkg and nvc_store.
//
// Append commands (opcode 0 and 1) take one character each and are accepted
// one per cycle while no compare is running; zero bytes are ignored and
// characters past MAX_LEN are dropped with the overflow flag set. A compare
// (opcode 2) stalls the command channel while a 20-step microprogram walks
// both stores through their single read ports, one step per cycle, the last
// step waiting while a result is still held in the result register. Each
// character pair is read by a fetch step and a latch step through the
// registered read ports and then tested; digit runs and skipped leading
// zeros on either side use their own fetch and latch steps. The compare
// then posts one result, clears both stores and releases the channel.
// Stores need no clearing pass after reset.
`default_nettype none

module natural_version_compare #(
	parameter int MAX_LEN = nvc_pkg::MAX_LEN_DEF,
	localparam int IW = $clog2(MAX_LEN + 2)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire logic [1:0]        opcode,
	input  wire logic [7:0]        char_value,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic signed [8:0]      order_value,
	output logic                   overflowed
);

	nvc_pkg::store_stat_t sa, sb;
	nvc_pkg::ctrl_word_t  cw;
	nvc_pkg::pc_t         pc_q;
	logic                 busy_q;
	logic [IW-1:0]        i_q, j_q;
	logic [7:0]           a_q, b_q;
	logic signed [4:0]    diff_q;
	logic                 trunc_q;
	logic                 res_valid_q;
	logic signed [8:0]    order_q;
	logic                 ovf_q;
	logic                 cmd_xfer;
	logic                 push_a, push_b;
	logic                 fin;
	logic                 jump;
	logic                 dig_a, dig_b;
	logic signed [8:0]    sub_ab;
	logic signed [8:0]    res_val;

	// Command transfer and appends
	assign cmd_stall = busy_q;
	assign cmd_xfer  = cmd_valid && !busy_q;
	assign push_a = cmd_xfer && (opcode == nvc_pkg::OP_APPEND_FIRST)
		&& (char_value != nvc_pkg::CH_NUL);
	assign push_b = cmd_xfer && (opcode == nvc_pkg::OP_APPEND_SECOND)
		&& (char_value != nvc_pkg::CH_NUL);

	nvc_store #(.MAX_LEN(MAX_LEN)) u_first (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_a),
		.push_char (char_value),
		.clear     (fin),
		.rd_idx    (i_q),
		.stat      (sa)
	);

	nvc_store #(.MAX_LEN(MAX_LEN)) u_second (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_b),
		.push_char (char_value),
		.clear     (fin),
		.rd_idx    (j_q),
		.stat      (sb)
	);

	// Decode the current step
	assign cw     = nvc_pkg::rom_word(pc_q);
	assign dig_a  = nvc_pkg::is_digit(a_q);
	assign dig_b  = nvc_pkg::is_digit(b_q);
	assign sub_ab = $signed({1'b0, a_q}) - $signed({1'b0, b_q});

	always_comb begin
		case (cw.cond)
			nvc_pkg::C_NONE:       jump = 1'b0;
			nvc_pkg::C_ALWAYS:     jump = 1'b1;
			nvc_pkg::C_ANY:        jump = sa.is_any || sb.is_any;
			nvc_pkg::C_NOT_BOTH:   jump = !(dig_a && dig_b);
			nvc_pkg::C_A_NOT_ZERO: jump = (a_q != nvc_pkg::CH_ZERO);
			nvc_pkg::C_B_NOT_ZERO: jump = (b_q != nvc_pkg::CH_ZERO);
			nvc_pkg::C_DIG_DIFFER: jump = (dig_a != dig_b);
			nvc_pkg::C_DIFF_NZ:    jump = (diff_q != 5'sd0);
			nvc_pkg::C_CONTINUE:   jump = (a_q != nvc_pkg::CH_NUL)
				&& (b_q != nvc_pkg::CH_NUL) && (a_q == b_q);
			default:               jump = 1'b0;
		endcase
	end

	// Pick the result value
	always_comb begin
		case (cw.res_sel)
			nvc_pkg::RES_SUB:  res_val = sub_ab;
			nvc_pkg::RES_SIGN: res_val = dig_a ? 9'sd1 : -9'sd1;
			nvc_pkg::RES_DIFF: res_val = 9'(diff_q);
			default:           res_val = 9'sd0;
		endcase
	end

	// Finish once the result register is free or draining
	assign fin = busy_q && (cw.res_sel != nvc_pkg::RES_NONE)
		&& (!res_valid_q || !res_stall);

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pc_q    <= nvc_pkg::PC_CHK_ANY;
			i_q     <= '0;
			j_q     <= '0;
			trunc_q <= 1'b0;
		end else begin
			if ((push_a && sa.full) || (push_b && sb.full)) begin
				trunc_q <= 1'b1;
			end
			if (!busy_q) begin
				if (cmd_xfer && (opcode == nvc_pkg::OP_COMPARE)) begin
					busy_q <= 1'b1;
					pc_q   <= nvc_pkg::PC_CHK_ANY;
					i_q    <= '0;
					j_q    <= '0;
				end
			end else if (cw.res_sel != nvc_pkg::RES_NONE) begin
				if (fin) begin
					busy_q  <= 1'b0;
					trunc_q <= 1'b0;
				end
			end else begin
				pc_q <= jump ? cw.target : pc_q + nvc_pkg::PC_W'(1);
				if (cw.inc_i) begin
					i_q <= i_q + IW'(1);
				end
				if (cw.inc_j) begin
					j_q <= j_q + IW'(1);
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd_xfer && (opcode == nvc_pkg::OP_COMPARE)) begin
			diff_q <= 5'sd0;
		end else if (busy_q) begin
			if (cw.lat_a) begin
				a_q <= sa.ch;
			end
			if (cw.lat_b) begin
				b_q <= sb.ch;
			end
			if (cw.diff_upd && (diff_q == 5'sd0)) begin
				diff_q <= 5'(sub_ab);
			end
		end
	end

	// Result register: load on finish, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			order_q <= res_val;
			ovf_q   <= trunc_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign order_value = order_q;
	assign overflowed  = ovf_q;

	// Checks
	a_pc_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q <= nvc_pkg::PC_LAST))
		else $error("sequencer stepped past the program");

	a_idx_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ((i_q <= IW'(MAX_LEN + 1)) && (j_q <= IW'(MAX_LEN + 1))))
		else $error("walk index ran past the store end");

	a_res_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(busy_q))
		else $error("result posted without a compare in progress");

	a_trunc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (!trunc_q && !busy_q))
		else $error("overflow flag or busy not cleared after compare");

endmodule

`default_nettype wire
